FILE: rtl/lkc_pkg.sv
// Package for the LRU keyed cache: shared constants, types and codes.
`default_nettype none

package lkc_pkg;

   // Fixed widths of the port fields.
   localparam int CMD_BITS      = 1;
   localparam int REQ_KEY_BITS  = 32;
   localparam int DATA_BITS     = 32;
   localparam int CAP_BITS      = 5;

   // Defaults of the top-level parameters.
   localparam int ENTRIES_DEFAULT  = 16;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   // Operation codes on the request channel.
   localparam logic [CMD_BITS-1:0] CMD_GET = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // What the update step does to the table.
   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT
   } upd_type;

   typedef struct packed {
      logic    load_req;
      logic    lookup;
      logic    update;
      upd_type upd_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic cmd_put;
   } dp_stat_type;

endpackage : lkc_pkg

`default_nettype wire

FILE: rtl/lkc_cell.sv
// One table entry: stored key, recency rank and the key comparator.
`default_nettype none

module lkc_cell import lkc_pkg::*; #(
   parameter int KEY_BITS  = KEY_BITS_DEFAULT,
   parameter int RANK_BITS = $clog2(ENTRIES_DEFAULT)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid,
   input  wire logic [KEY_BITS-1:0]  cmp_key,
   input  wire logic                 is_slot,
   input  wire logic                 ins_en,
   input  wire logic                 touch_en,
   input  wire logic [RANK_BITS-1:0] touch_rank,
   output logic                      match,
   output logic [RANK_BITS-1:0]      rank
);

   logic [KEY_BITS-1:0]  key_ff;
   logic [KEY_BITS-1:0]  key_in;
   logic [RANK_BITS-1:0] rank_ff;
   logic [RANK_BITS-1:0] rank_in;

   assign match = valid && (key_ff == cmp_key);
   assign rank  = rank_ff;

   always_comb begin
      key_in = key_ff;
      if (ins_en && is_slot) begin
         key_in = cmp_key;
      end
   end

   // The touched entry becomes most recent; every valid entry newer than it ages by one.
   always_comb begin
      rank_in = rank_ff;
      if (touch_en) begin
         if (is_slot) begin
            rank_in = '0;
         end else if (valid && (rank_ff < touch_rank)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else begin
         rank_ff <= rank_in;
      end
   end

endmodule : lkc_cell

`default_nettype wire

FILE: rtl/lkc_datapath.sv
// Datapath: request registers, entry cells, value memory, capacity and result registers.
`default_nettype none

module lkc_datapath import lkc_pkg::*; #(
   parameter int ENTRIES  = ENTRIES_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_cmd_type            cmd,
   output dp_stat_type                  stat,
   input  wire logic [CMD_BITS-1:0]     req_cmd,
   input  wire logic [REQ_KEY_BITS-1:0] req_lookup_key,
   input  wire logic [DATA_BITS-1:0]    req_file_size,
   input  wire logic [DATA_BITS-1:0]    req_access_stamp,
   input  wire logic                    csr_wr_en,
   input  wire logic [CAP_BITS-1:0]     csr_wr_data,
   output logic                         rsp_hit,
   output logic                         rsp_evicted,
   output logic [DATA_BITS-1:0]         rsp_size_out,
   output logic [DATA_BITS-1:0]         rsp_stamp_out
);

   localparam int SLOT_BITS = $clog2(ENTRIES);
   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int WIDE_BITS = (KEY_BITS > REQ_KEY_BITS) ? KEY_BITS : REQ_KEY_BITS;

   // Request registers.
   logic [CMD_BITS-1:0]  req_cmd_ff,   req_cmd_in;
   logic [KEY_BITS-1:0]  req_key_ff,   req_key_in;
   logic [DATA_BITS-1:0] req_size_ff,  req_size_in;
   logic [DATA_BITS-1:0] req_stamp_ff, req_stamp_in;
   logic [WIDE_BITS-1:0] key_wide;

   // Control state.
   logic [CAP_BITS-1:0]  cap_ff,  cap_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 hit_ff,  hit_in;
   logic                 evict_ff, evict_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOT_BITS-1:0] thresh_ff, thresh_in;

   // Lookup results.
   logic [ENTRIES-1:0]   valid;
   logic [ENTRIES-1:0]   match;
   logic [SLOT_BITS-1:0] rank [ENTRIES];
   logic [SLOT_BITS-1:0] found_slot;
   logic [SLOT_BITS-1:0] found_rank;
   logic [SLOT_BITS-1:0] old_slot;
   logic [FILL_BITS-1:0] fill_dec;
   logic [SLOT_BITS-1:0] last_rank;
   logic [SLOT_BITS-1:0] fill_slot;
   logic [FILL_BITS-1:0] cap_eff;
   logic                 hit_now;
   logic                 evict_now;

   logic                 touch_en;
   logic                 ins_en;
   logic                 mem_we;
   logic                 read_hit;

   // Size and stamp of each entry, packed as one word.
   logic [2*DATA_BITS-1:0] value_mem [ENTRIES];

   logic                 rsp_hit_ff;
   logic                 rsp_evicted_ff;
   logic [DATA_BITS-1:0] rsp_size_ff;
   logic [DATA_BITS-1:0] rsp_stamp_ff;

   assign key_wide = WIDE_BITS'(req_lookup_key);

   always_comb begin
      req_cmd_in   = req_cmd_ff;
      req_key_in   = req_key_ff;
      req_size_in  = req_size_ff;
      req_stamp_in = req_stamp_ff;
      if (cmd.load_req) begin
         req_cmd_in   = req_cmd;
         req_key_in   = key_wide[KEY_BITS-1:0];
         req_size_in  = req_file_size;
         req_stamp_in = req_access_stamp;
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff   <= req_cmd_in;
      req_key_ff   <= req_key_in;
      req_size_ff  <= req_size_in;
      req_stamp_ff <= req_stamp_in;
   end

   // Slots are filled from zero upward and the fill never shrinks, so an entry is
   // valid exactly when its index lies below the fill count.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      localparam logic [FILL_BITS-1:0] IDX_FILL = FILL_BITS'(g);
      localparam logic [SLOT_BITS-1:0] IDX_SLOT = SLOT_BITS'(g);

      assign valid[g] = IDX_FILL < fill_ff;

      lkc_cell #(
         .KEY_BITS  (KEY_BITS),
         .RANK_BITS (SLOT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .valid      (valid[g]),
         .cmp_key    (req_key_ff),
         .is_slot    (slot_ff == IDX_SLOT),
         .ins_en     (ins_en),
         .touch_en   (touch_en),
         .touch_rank (thresh_ff),
         .match      (match[g]),
         .rank       (rank[g])
      );
   end

   assign fill_dec  = fill_ff - 1'b1;
   assign last_rank = fill_dec[SLOT_BITS-1:0];
   assign fill_slot = fill_ff[SLOT_BITS-1:0];
   assign hit_now   = |match;

   // Keys of valid entries are unique and ranks are distinct, so both encoders
   // see at most one set input and an OR suffices.
   always_comb begin
      found_slot = '0;
      found_rank = '0;
      old_slot   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            found_slot = found_slot | SLOT_BITS'(i);
            found_rank = found_rank | rank[i];
         end
         if (valid[i] && (rank[i] == last_rank)) begin
            old_slot = old_slot | SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = FILL_BITS'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = FILL_BITS'(ENTRIES);
      end else begin
         cap_eff = FILL_BITS'(cap_ff);
      end
   end

   assign evict_now = fill_ff >= cap_eff;

   // An insert is a touch of the slot that receives the entry: the evicted slot
   // ages everything below the oldest rank, a fresh slot ages every valid entry.
   always_comb begin
      hit_in    = hit_ff;
      evict_in  = evict_ff;
      slot_in   = slot_ff;
      thresh_in = thresh_ff;
      if (cmd.lookup) begin
         hit_in   = hit_now;
         evict_in = evict_now;
         if (hit_now) begin
            slot_in   = found_slot;
            thresh_in = found_rank;
         end else if (evict_now) begin
            slot_in   = old_slot;
            thresh_in = last_rank;
         end else begin
            slot_in   = fill_slot;
            thresh_in = fill_slot;
         end
      end
   end

   assign touch_en = cmd.update && (cmd.upd_kind != UPD_NONE);
   assign ins_en   = cmd.update && (cmd.upd_kind == UPD_INSERT);
   assign mem_we   = touch_en && (req_cmd_ff == CMD_PUT);
   assign read_hit = hit_ff && (req_cmd_ff == CMD_GET);

   always_comb begin
      fill_in = fill_ff;
      if (ins_en && !evict_ff) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         fill_ff   <= '0;
         hit_ff    <= 1'b0;
         evict_ff  <= 1'b0;
         slot_ff   <= '0;
         thresh_ff <= '0;
      end else begin
         cap_ff    <= cap_in;
         fill_ff   <= fill_in;
         hit_ff    <= hit_in;
         evict_ff  <= evict_in;
         slot_ff   <= slot_in;
         thresh_ff <= thresh_in;
      end
   end

   // The result registers double as the registered read port of the memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem[slot_ff] <= {req_size_ff, req_stamp_ff};
      end
      if (cmd.update) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= ins_en && evict_ff;
         if (read_hit) begin
            {rsp_size_ff, rsp_stamp_ff} <= value_mem[slot_ff];
         end else begin
            rsp_size_ff  <= '0;
            rsp_stamp_ff <= '0;
         end
      end
   end

   assign stat.hit     = hit_ff;
   assign stat.cmd_put = (req_cmd_ff == CMD_PUT);

   assign rsp_hit       = rsp_hit_ff;
   assign rsp_evicted   = rsp_evicted_ff;
   assign rsp_size_out  = rsp_size_ff;
   assign rsp_stamp_out = rsp_stamp_ff;

endmodule : lkc_datapath

`default_nettype wire

FILE: rtl/lkc_ctrl.sv
// Controller: sequences accept, lookup and update, and owns the result valid flag.
`default_nettype none

module lkc_ctrl import lkc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire dp_stat_type  stat,
   output ctrl_cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new beat once the old one leaves.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.lookup   = 1'b0;
      cmd.update   = 1'b0;
      cmd.upd_kind = UPD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = out_free;
            if (stat.hit) begin
               cmd.upd_kind = UPD_TOUCH;
            end else if (stat.cmd_put) begin
               cmd.upd_kind = UPD_INSERT;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : lkc_ctrl

`default_nettype wire

FILE: rtl/lru_keyed_cache_top.sv
// Top level of the fully associative LRU keyed cache.
//
//   Channel   Direction  Handshake              Beat contents
//   req_      in         req_valid/req_ready    cmd, lookup_key, file_size, access_stamp
//   rsp_      out        rsp_valid/rsp_ready    hit, evicted, size_out, stamp_out
//   csr_      in         csr_wr_en              capacity_in_use
//
// Each beat passes through three steps: accept, a parallel key compare in all entry cells,
// then the rank update with the value memory write or read.
// The next request beat is accepted while a result still waits in the output register;
// a stalled result holds the update step until that register frees.
// Reset is synchronous and empties the table; capacity returns to 16.
`default_nettype none

module lru_keyed_cache_top import lkc_pkg::*; #(
   parameter int ENTRIES  = ENTRIES_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [CMD_BITS-1:0]     req_cmd,
   input  wire logic [REQ_KEY_BITS-1:0] req_lookup_key,
   input  wire logic [DATA_BITS-1:0]    req_file_size,
   input  wire logic [DATA_BITS-1:0]    req_access_stamp,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_hit,
   output logic                         rsp_evicted,
   output logic [DATA_BITS-1:0]         rsp_size_out,
   output logic [DATA_BITS-1:0]         rsp_stamp_out,
   input  wire logic                    csr_wr_en,
   input  wire logic [CAP_BITS-1:0]     csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   lkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lkc_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_lookup_key   (req_lookup_key),
      .req_file_size    (req_file_size),
      .req_access_stamp (req_access_stamp),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_size_out     (rsp_size_out),
      .rsp_stamp_out    (rsp_stamp_out)
   );

endmodule : lru_keyed_cache_top

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the LRU keyed cache: directed and randomized get/put traffic.
`timescale 1ns / 1ps

module testbench;
   import lkc_pkg::*;

   localparam int LINES       = ENTRIES_DEFAULT;
   localparam int POOL_SIZE   = 20;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [DATA_BITS-1:0] size;
      logic [DATA_BITS-1:0] stamp;
   } lookup_reply_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CMD_BITS-1:0]     req_cmd = CMD_GET;
   logic [REQ_KEY_BITS-1:0] req_lookup_key = '0;
   logic [DATA_BITS-1:0]    req_file_size = '0;
   logic [DATA_BITS-1:0]    req_access_stamp = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_hit;
   logic                    rsp_evicted;
   logic [DATA_BITS-1:0]    rsp_size_out;
   logic [DATA_BITS-1:0]    rsp_stamp_out;
   logic                    csr_wr_en = 1'b0;
   logic [CAP_BITS-1:0]     csr_wr_data = '0;

   // Shadow copy of the cache contents, kept in step with every accepted request beat.
   logic [REQ_KEY_BITS-1:0] line_key   [LINES];
   logic [DATA_BITS-1:0]    line_size  [LINES];
   logic [DATA_BITS-1:0]    line_stamp [LINES];
   logic                    line_used  [LINES];
   int                      line_age   [LINES];
   int                      lines_filled;
   logic [CAP_BITS-1:0]     capacity_setting;

   lookup_reply_type        pending_replies[$];
   logic [REQ_KEY_BITS-1:0] key_pool[POOL_SIZE];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int cycle_count    = 0;
   int beats_sent     = 0;
   int replies_seen   = 0;
   int hits_seen      = 0;
   int evictions_seen = 0;
   int mismatch_count = 0;
   int capacity_writes = 0;

   lru_keyed_cache_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_lookup_key   (req_lookup_key),
      .req_file_size    (req_file_size),
      .req_access_stamp (req_access_stamp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_size_out     (rsp_size_out),
      .rsp_stamp_out    (rsp_stamp_out),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int capacity_limit();
      int limit;
      limit = int'(capacity_setting);
      if (limit < 1) limit = 1;
      if (limit > LINES) limit = LINES;
      return limit;
   endfunction

   function automatic lookup_reply_type predict_reply(logic [CMD_BITS-1:0] cmd,
                                                      logic [REQ_KEY_BITS-1:0] key,
                                                      logic [DATA_BITS-1:0] size,
                                                      logic [DATA_BITS-1:0] stamp);
      lookup_reply_type reply;
      int found;
      int slot;
      int oldest;
      int rank;
      reply = '0;
      found = -1;
      slot = -1;
      oldest = -1;
      for (int i = 0; i < LINES; i++) begin
         if (found < 0 && line_used[i] && line_key[i] == key) found = i;
      end
      if (found >= 0) begin
         reply.hit = 1'b1;
         if (cmd == CMD_GET) begin
            reply.size  = line_size[found];
            reply.stamp = line_stamp[found];
         end else begin
            line_size[found]  = size;
            line_stamp[found] = stamp;
         end
         // Everything more recent than the touched line ages by one.
         rank = line_age[found];
         for (int i = 0; i < LINES; i++) begin
            if (line_used[i] && line_age[i] < rank) line_age[i]++;
         end
         line_age[found] = 0;
      end else if (cmd == CMD_PUT) begin
         // A miss evicts at most one line, even when the table is over capacity.
         if (lines_filled >= capacity_limit() && lines_filled > 0) begin
            for (int i = 0; i < LINES; i++) begin
               if (line_used[i] && (oldest < 0 || line_age[i] > line_age[oldest])) oldest = i;
            end
            if (oldest >= 0) begin
               line_used[oldest] = 1'b0;
               line_age[oldest]  = 0;
               lines_filled--;
               reply.evicted = 1'b1;
            end
         end
         for (int i = 0; i < LINES; i++) begin
            if (slot < 0 && !line_used[i]) slot = i;
         end
         if (slot >= 0) begin
            for (int i = 0; i < LINES; i++) begin
               if (line_used[i]) line_age[i]++;
            end
            line_used[slot]  = 1'b1;
            line_key[slot]   = key;
            line_size[slot]  = size;
            line_stamp[slot] = stamp;
            line_age[slot]   = 0;
            lines_filled++;
         end
      end
      return reply;
   endfunction

   // Drives one request beat, optionally after an idle gap, and returns at its acceptance.
   task automatic send_beat(logic [CMD_BITS-1:0] cmd, logic [REQ_KEY_BITS-1:0] key,
                            logic [DATA_BITS-1:0] size, logic [DATA_BITS-1:0] stamp);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_lookup_key   <= key;
      req_file_size    <= size;
      req_access_stamp <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_replies.push_back(predict_reply(cmd, key, size, stamp));
      beats_sent++;
   endtask

   // Holds the request side quiet until every outstanding result has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_BITS-1:0] value);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_setting = value;
      capacity_writes++;
   endtask

   task automatic test_get_put_basics();
      send_beat(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_PUT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_beat(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_beat(CMD_GET, 32'h0000_0000, $urandom(), $urandom());
      send_beat(CMD_PUT, 32'h0000_0000, 32'h1234_5678, 32'h9ABC_DEF0);
      send_beat(CMD_GET, 32'h0000_0000, $urandom(), $urandom());
   endtask

   task automatic test_capacity_limits();
      // Capacity zero behaves as one: every put miss replaces the oldest line.
      set_capacity(5'd0);
      send_beat(CMD_PUT, 32'h0000_0011, 32'hA5A5_0011, 32'h5A5A_0011);
      send_beat(CMD_PUT, 32'h0000_0022, 32'hA5A5_0022, 32'h5A5A_0022);
      send_beat(CMD_GET, 32'h0000_0011, 32'h0, 32'h0);
      send_beat(CMD_PUT, 32'h0000_0033, 32'hA5A5_0033, 32'h5A5A_0033);
      send_beat(CMD_GET, 32'h0000_0022, 32'h0, 32'h0);
      set_capacity(5'd4);
      send_beat(CMD_PUT, 32'h0000_0044, 32'hA5A5_0044, 32'h5A5A_0044);
      send_beat(CMD_PUT, 32'h0000_0055, 32'hA5A5_0055, 32'h5A5A_0055);
      send_beat(CMD_GET, 32'h0000_0011, 32'h0, 32'h0);
      send_beat(CMD_PUT, 32'h0000_0066, 32'hA5A5_0066, 32'h5A5A_0066);
      // Values above the table size act as a full table.
      set_capacity(5'd31);
      send_beat(CMD_PUT, 32'h0000_0077, 32'hA5A5_0077, 32'h5A5A_0077);
      // Lowering capacity under the fill level: a miss trims only one line.
      set_capacity(5'd1);
      send_beat(CMD_PUT, 32'h0000_0088, 32'hA5A5_0088, 32'h5A5A_0088);
      send_beat(CMD_GET, 32'h0000_0055, 32'h0, 32'h0);
      send_beat(CMD_GET, 32'h0000_0088, 32'h0, 32'h0);
   endtask

   task automatic test_lru_traffic();
      int idle_send [4];
      int idle_rsp  [4];
      int fixed_caps[5];
      int span;
      logic [REQ_KEY_BITS-1:0] key;
      logic [CMD_BITS-1:0] cmd;
      idle_send  = '{0, 55, 0, 30};
      idle_rsp   = '{0, 0, 55, 30};
      fixed_caps = '{16, 1, 31, 0, 5};
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
      for (int phase = 0; phase < 4; phase++) begin
         for (int chunk = 0; chunk < 4; chunk++) begin
            if (phase * 4 + chunk < 5) set_capacity(CAP_BITS'(fixed_caps[phase * 4 + chunk]));
            else set_capacity(CAP_BITS'($urandom_range(31)));
            send_idle_pct = idle_send[phase];
            rsp_stall_pct = idle_rsp[phase];
            key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom();
            // Draw keys mostly from a working set slightly larger than the capacity.
            span = capacity_limit() + 3;
            if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
            for (int n = 0; n < 60; n++) begin
               if ($urandom_range(99) < 85) key = key_pool[$urandom_range(span)];
               else key = $urandom();
               cmd = ($urandom_range(1) == 1) ? CMD_PUT : CMD_GET;
               send_beat(cmd, key, $urandom(), $urandom());
            end
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drain_replies();
   endtask

   always @(posedge clock) begin
      rsp_ready <= (rsp_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      lookup_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (rsp_hit) hits_seen++;
         if (rsp_evicted) evictions_seen++;
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result beat %0d arrived with nothing outstanding", replies_seen);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_hit !== want.hit || rsp_evicted !== want.evicted ||
                rsp_size_out !== want.size || rsp_stamp_out !== want.stamp) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result beat %0d: expected hit=%0b evicted=%0b size=%h stamp=%h",
                           replies_seen, want.hit, want.evicted, want.size, want.stamp);
                  $display("result beat %0d: got hit=%0b evicted=%0b size=%h stamp=%h",
                           replies_seen, rsp_hit, rsp_evicted, rsp_size_out, rsp_stamp_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_replies.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LINES; i++) begin
         line_key[i]   = '0;
         line_size[i]  = '0;
         line_stamp[i] = '0;
         line_used[i]  = 1'b0;
         line_age[i]   = 0;
      end
      lines_filled = 0;
      capacity_setting = CAP_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_get_put_basics();
      test_capacity_limits();
      test_lru_traffic();

      repeat (10) @(posedge clock);
      if (pending_replies.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", pending_replies.size());
      end
      $display("covered %0d request beats across %0d capacity writes and four idling mixes",
               beats_sent, capacity_writes);
      $display("results: %0d hits, %0d evictions, %0d mismatches",
               hits_seen, evictions_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
